// ===== rtl/hctnc_pkg.sv =====
// Shared types and constants for the hashed cell table with neighbour count.
// No dependencies; used by hashed_cell_table_neighbour_count.
`timescale 1ns / 1ps

package hctnc_pkg;

    localparam int DIM_W = 11;
    localparam int NB_W  = 4;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_UPDATE = 3'd1,
        OP_INSERT = 3'd2,
        OP_COUNT  = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_FOUND   = 2'd1,
        ST_BUCKET_FULL = 2'd2
    } t_status;

endpackage

// ===== rtl/hctnc_hash.sv =====
// Bucket hash: Cantor pairing of (x, y) reduced modulo the bucket count.
// One multiply, one add, then a bit-serial remainder unless the count is a power of two.
`timescale 1ns / 1ps

module hctnc_hash #(
    parameter int NUM_BUCKETS = 4096,
    parameter int COORD_BITS  = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [COORD_BITS-1:0]          i_x,
    input  logic [COORD_BITS-1:0]          i_y,
    output logic                           o_done,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_bucket
);

    localparam int  CW      = COORD_BITS;
    localparam int  PW      = 2 * CW + 2;
    localparam int  BW      = $clog2(NUM_BUCKETS);
    localparam int  PXW     = (PW > BW) ? PW : BW;
    localparam int  RW      = BW + 1;
    localparam int  CNT_W   = $clog2(PXW + 1);
    localparam bit  IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_ADD,
        H_MOD
    } t_hstate;

    t_hstate            r_state;
    logic [CW-1:0]      r_x;
    logic [CW-1:0]      r_y;
    logic [PW:0]        r_prod;
    logic [PXW-1:0]     r_p;
    logic [BW-1:0]      r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [BW-1:0]      r_bucket;

    logic [CW:0]        w_s;
    logic [CW+1:0]      w_s1;
    logic [PXW-1:0]     w_sum;
    logic [RW-1:0]      w_shift;
    logic [RW-1:0]      w_red;

    assign w_s     = (CW+1)'(r_x) + (CW+1)'(r_y);
    assign w_s1    = (CW+2)'(w_s) + (CW+2)'(1);
    assign w_sum   = PXW'(r_prod[PW:1]) + PXW'(r_y);
    assign w_shift = {r_rem, r_p[PXW-1]};
    assign w_red   = (w_shift >= RW'(NUM_BUCKETS)) ? (w_shift - RW'(NUM_BUCKETS)) : w_shift;

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_y     <= i_y;
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    r_prod  <= (PW+1)'(w_s) * (PW+1)'(w_s1);
                    r_state <= H_ADD;
                end
                H_ADD: begin
                    if (IS_POW2) begin
                        r_bucket <= w_sum[BW-1:0];
                        r_done   <= 1'b1;
                        r_state  <= H_IDLE;
                    end else begin
                        r_p     <= w_sum;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(PXW);
                        r_state <= H_MOD;
                    end
                end
                H_MOD: begin
                    r_rem <= w_red[BW-1:0];
                    r_p   <= {r_p[PXW-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_bucket <= w_red[BW-1:0];
                        r_done   <= 1'b1;
                        r_state  <= H_IDLE;
                    end
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_bucket;

endmodule

// ===== rtl/hashed_cell_table_neighbour_count.sv =====
// Top level: hashed cell table with lookup, update, insert, clear and neighbour count.
// Depends on hctnc_pkg and hctnc_hash.
//
// Use: items enter on i_valid/o_ready (op, x, y, live bit); one result item per
// input item leaves on o_valid/i_ready (live bit, neighbour count, status).
// Grid size is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// One item is worked at a time; o_ready is high only when the sequencer is idle.
// Every table access goes through one probe: hash (with a bit-serial remainder
// unless the bucket count is a power of two), fill read and a scan of the occupied
// slots on the single entry memory port; insert writes the next free slot instead.
// Lookup and update: one probe. Count: up to ten probes (the cell and its clipped
// 3x3 window). Clear: one pass over every bucket. Unused ops: no table access.
// After reset a clearing pass empties every bucket; o_ready stays low meanwhile,
// configuration writes are taken as ever.
// A result waits in the output register while i_ready is low; the next
// item is still taken, and the block holds only before loading a further result.
`timescale 1ns / 1ps

module hashed_cell_table_neighbour_count #(
    parameter int NUM_BUCKETS  = 4096,
    parameter int BUCKET_SLOTS = 4,
    parameter int COORD_BITS   = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_op,
    input  logic [COORD_BITS-1:0]       i_x_coord,
    input  logic [COORD_BITS-1:0]       i_y_coord,
    input  logic                        i_live_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_live_out,
    output logic [hctnc_pkg::NB_W-1:0]  o_neighbours,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [hctnc_pkg::DIM_W-1:0] i_cfg_data
);

    localparam int CW  = COORD_BITS;
    localparam int BW  = $clog2(NUM_BUCKETS);
    localparam int AW  = $clog2(NUM_BUCKETS * BUCKET_SLOTS);
    localparam int FW  = $clog2(BUCKET_SLOTS + 1);
    localparam int EW  = 2 * CW + 1;
    localparam int WW  = (CW + 1 > hctnc_pkg::DIM_W) ? CW + 1 : hctnc_pkg::DIM_W;
    localparam int NBW = hctnc_pkg::NB_W;
    localparam logic [WW-1:0] COORD_MAX   = WW'((1 << COORD_BITS) - 1);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FILL_RD,
        S_FILL_WAIT,
        S_SCAN,
        S_CMP,
        S_PROBE_END,
        S_WIN,
        S_FINISH
    } t_state;

    t_state                     r_state;
    logic                       r_boot;
    logic [BW-1:0]              r_ptr;
    logic [hctnc_pkg::DIM_W-1:0] r_grid_w;
    logic [hctnc_pkg::DIM_W-1:0] r_grid_h;

    logic [2:0]                 r_op;
    logic                       r_live_in;
    logic [CW-1:0]              r_px;
    logic [CW-1:0]              r_py;
    logic                       r_hash_start;
    logic [BW-1:0]              r_bucket;
    logic [AW-1:0]              r_base;
    logic [FW-1:0]              r_n;
    logic [FW-1:0]              r_slot;
    logic                       r_found;
    logic                       r_hit_live;
    logic [AW-1:0]              r_hit_addr;

    logic                       r_self_phase;
    logic                       r_self_live;
    logic                       r_in_grid;
    logic [NBW-1:0]             r_cnt;
    logic [WW-1:0]              r_x0;
    logic [WW-1:0]              r_x1;
    logic [WW-1:0]              r_y0;
    logic [WW-1:0]              r_y1;
    logic [WW-1:0]              r_i;
    logic [WW-1:0]              r_j;

    logic                       r_res_live;
    logic [NBW-1:0]             r_res_nb;
    hctnc_pkg::t_status         r_res_status;

    logic                       r_o_valid;
    logic                       r_o_live;
    logic [NBW-1:0]             r_o_nb;
    logic [1:0]                 r_o_status;

    logic [FW-1:0]              r_fill_mem [NUM_BUCKETS];
    logic [FW-1:0]              r_fill_q;
    logic [EW-1:0]              r_ent_mem [NUM_BUCKETS * BUCKET_SLOTS];
    logic [EW-1:0]              r_ent_q;

    logic                       w_accept;
    logic                       w_hash_done;
    logic [BW-1:0]              w_bucket;
    logic [WW-1:0]              w_xw;
    logic [WW-1:0]              w_yw;
    logic [WW-1:0]              w_x2;
    logic [WW-1:0]              w_y2;
    logic [WW-1:0]              w_gw;
    logic [WW-1:0]              w_gh;
    logic                       w_fill_we;
    logic [BW-1:0]              w_fill_addr;
    logic [FW-1:0]              w_fill_wdata;
    logic                       w_ent_we;
    logic [AW-1:0]              w_ent_addr;
    logic                       w_room;

    hctnc_hash #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .COORD_BITS  (COORD_BITS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_hash_start),
        .i_x      (r_px),
        .i_y      (r_py),
        .o_done   (w_hash_done),
        .o_bucket (w_bucket)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_xw = WW'(i_x_coord);
    assign w_yw = WW'(i_y_coord);
    assign w_x2 = w_xw + WW'(2);
    assign w_y2 = w_yw + WW'(2);
    assign w_gw = WW'(r_grid_w);
    assign w_gh = WW'(r_grid_h);
    assign w_room = (r_fill_q < FW'(BUCKET_SLOTS));

    // memory port control
    always_comb begin
        w_fill_we    = 1'b0;
        w_fill_addr  = r_bucket;
        w_fill_wdata = r_fill_q + FW'(1);
        w_ent_we     = 1'b0;
        w_ent_addr   = r_base + AW'(r_slot);
        if (r_state == S_CLEAR) begin
            w_fill_we    = 1'b1;
            w_fill_addr  = r_ptr;
            w_fill_wdata = '0;
        end
        if (r_state == S_FILL_WAIT && r_op == hctnc_pkg::OP_INSERT && w_room) begin
            w_fill_we  = 1'b1;
            w_ent_we   = 1'b1;
            w_ent_addr = r_base + AW'(r_fill_q);
        end
        if (r_state == S_PROBE_END && r_op == hctnc_pkg::OP_UPDATE && r_found) begin
            w_ent_we   = 1'b1;
            w_ent_addr = r_hit_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            r_fill_mem[w_fill_addr] <= w_fill_wdata;
        end
        r_fill_q <= r_fill_mem[w_fill_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            r_ent_mem[w_ent_addr] <= {r_px, r_py, r_live_in};
        end
        r_ent_q <= r_ent_mem[w_ent_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= hctnc_pkg::DIM_RESET;
            r_grid_h <= hctnc_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == hctnc_pkg::CFG_GRID_WIDTH) begin
                r_grid_w <= i_cfg_data;
            end else begin
                r_grid_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_boot       <= 1'b1;
            r_ptr        <= '0;
            r_hash_start <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_hash_start <= 1'b0;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + BW'(1);
                    if (r_ptr == LAST_BUCKET) begin
                        r_ptr   <= '0;
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_FINISH;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= i_op;
                        r_live_in    <= i_live_in;
                        r_px         <= i_x_coord;
                        r_py         <= i_y_coord;
                        r_res_live   <= 1'b0;
                        r_res_nb     <= '0;
                        r_res_status <= hctnc_pkg::ST_OK;
                        r_cnt        <= '0;
                        r_self_phase <= 1'b1;
                        r_x0         <= (i_x_coord == '0) ? '0 : w_xw - WW'(1);
                        r_y0         <= (i_y_coord == '0) ? '0 : w_yw - WW'(1);
                        r_x1         <= (w_x2 < w_gw) ? w_x2 : w_gw;
                        r_y1         <= (w_y2 < w_gh) ? w_y2 : w_gh;
                        r_in_grid    <= (w_xw < w_gw) && (w_yw < w_gh);
                        case (i_op)
                            hctnc_pkg::OP_LOOKUP,
                            hctnc_pkg::OP_UPDATE,
                            hctnc_pkg::OP_INSERT,
                            hctnc_pkg::OP_COUNT: begin
                                r_hash_start <= 1'b1;
                                r_state      <= S_HASH;
                            end
                            hctnc_pkg::OP_CLEAR: begin
                                r_ptr   <= '0;
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_bucket <= w_bucket;
                        r_base   <= AW'(w_bucket) * AW'(BUCKET_SLOTS);
                        r_state  <= S_FILL_RD;
                    end
                end
                S_FILL_RD: begin
                    r_state <= S_FILL_WAIT;
                end
                S_FILL_WAIT: begin
                    r_n     <= r_fill_q;
                    r_slot  <= '0;
                    r_found <= 1'b0;
                    if (r_op == hctnc_pkg::OP_INSERT) begin
                        r_res_status <= w_room ? hctnc_pkg::ST_OK : hctnc_pkg::ST_BUCKET_FULL;
                        r_state      <= S_FINISH;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= (r_slot == r_n) ? S_PROBE_END : S_CMP;
                end
                S_CMP: begin
                    if (r_ent_q[EW-1:CW+1] == r_px && r_ent_q[CW:1] == r_py) begin
                        r_found    <= 1'b1;
                        r_hit_live <= r_ent_q[0];
                        r_hit_addr <= r_base + AW'(r_slot);
                        r_state    <= S_PROBE_END;
                    end else begin
                        r_slot  <= r_slot + FW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_PROBE_END: begin
                    case (r_op)
                        hctnc_pkg::OP_LOOKUP: begin
                            r_res_live <= r_found && r_hit_live;
                            r_state    <= S_FINISH;
                        end
                        hctnc_pkg::OP_UPDATE: begin
                            r_res_status <= r_found ? hctnc_pkg::ST_OK : hctnc_pkg::ST_NOT_FOUND;
                            r_state      <= S_FINISH;
                        end
                        hctnc_pkg::OP_COUNT: begin
                            if (r_self_phase) begin
                                r_self_live  <= r_found && r_hit_live;
                                r_self_phase <= 1'b0;
                                r_i          <= r_x0;
                                r_j          <= r_y0;
                            end else begin
                                r_cnt <= r_cnt + NBW'(r_found && r_hit_live);
                            end
                            r_state <= S_WIN;
                        end
                        default: begin
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_WIN: begin
                    if (r_i >= r_x1) begin
                        r_res_live <= r_self_live;
                        r_res_nb   <= (r_self_live && r_in_grid && r_cnt != '0)
                                      ? r_cnt - NBW'(1) : r_cnt;
                        r_state    <= S_FINISH;
                    end else if (r_j >= r_y1) begin
                        r_i <= r_i + WW'(1);
                        r_j <= r_y0;
                    end else if (r_i > COORD_MAX || r_j > COORD_MAX) begin
                        r_j <= r_j + WW'(1);
                    end else begin
                        r_px         <= r_i[CW-1:0];
                        r_py         <= r_j[CW-1:0];
                        r_j          <= r_j + WW'(1);
                        r_hash_start <= 1'b1;
                        r_state      <= S_HASH;
                    end
                end
                S_FINISH: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_live   <= r_res_live;
                        r_o_nb     <= r_res_nb;
                        r_o_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_live_out   = r_o_live;
    assign o_neighbours = r_o_nb;
    assign o_status     = r_o_status;

    a_hash_done_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> r_state == S_HASH)
        else $error("bucket hash finished outside a probe");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL_WAIT |-> r_fill_q <= FW'(BUCKET_SLOTS))
        else $error("bucket fill count above slot count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_nb <= NBW'(8))
        else $error("neighbour count above eight");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("item accepted but sequencer stayed idle");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && (!r_o_valid || i_ready)) |=> r_o_valid && r_state == S_IDLE)
        else $error("finished item not loaded into output register");

endmodule
